[rtl/jloc_pkg.sv]
// Package for the jet/lepton overlap cleaning block: item function codes, register
// indexes, reject reason codes, angle constants, sequencer states and status types.
// It depends on nothing else.
package jloc_pkg;

  // Function carried by an input item.
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_LEPTON = 2'd1,
    FUNC_JET    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_JET_MIN_PT    = 3'd0,
    REG_BTAG_MAX      = 3'd1,
    REG_PILEUP_MIN    = 3'd2,
    REG_ABS_ETA_MAX   = 3'd3,
    REG_LEPTON_MIN_PT = 3'd4,
    REG_CONE_RADIUS   = 3'd5
  } reg_idx_t;

  // Reject reason codes, first failing cut wins.
  typedef enum logic [2:0] {
    RSN_KEPT   = 3'd0,
    RSN_LOW_PT = 3'd1,
    RSN_BTAG   = 3'd2,
    RSN_PILEUP = 3'd3,
    RSN_ETA    = 3'd4,
    RSN_NEAR   = 3'd5
  } reason_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // 2*pi and pi in Q3.12.
  localparam logic [14:0] TWO_PI_Q12 = 15'd25736;
  localparam logic [14:0] PI_Q12     = 15'd12868;

  // Status of the cone distance pipeline.
  typedef struct packed {
    logic busy;     // a comparison is still in flight
    logic hit_vld;  // a comparison result is available this cycle
    logic hit;      // that lepton lies inside the cone
  } cone_stat_t;

endpackage

[rtl/jloc_cone_unit.sv]
// Three-stage delta-R pipeline: one stored lepton against the current jet per cycle.
// Depends on jloc_pkg for the angle constants and the status struct.
module jloc_cone_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     lep_vld,
  input  logic signed [15:0]       jet_eta,
  input  logic signed [14:0]       jet_phi,
  input  logic signed [15:0]       lep_eta,
  input  logic signed [14:0]       lep_phi,
  input  logic [29:0]              radius_sq,
  output jloc_pkg::cone_stat_t     stat
);
  import jloc_pkg::*;

  logic signed [16:0] deta;
  logic signed [15:0] dphi;
  logic [15:0]        adeta;
  logic [14:0]        adphi;
  logic [14:0]        wrap1;
  logic [14:0]        fold;

  logic        s1_vld_r;
  logic [15:0] s1_deta_r;
  logic [14:0] s1_dphi_r;
  logic        s2_vld_r;
  logic [31:0] s2_esq_r;
  logic [29:0] s2_psq_r;
  logic        s3_vld_r;
  logic        s3_hit_r;

  // Absolute differences, with dphi folded into [0, pi].
  always_comb begin
    deta  = 17'(jet_eta) - 17'(lep_eta);
    dphi  = 16'(jet_phi) - 16'(lep_phi);
    adeta = deta[16] ? 16'(-deta) : deta[15:0];
    adphi = dphi[15] ? 15'(-dphi) : dphi[14:0];
    wrap1 = (adphi > TWO_PI_Q12) ? 15'(adphi - TWO_PI_Q12) : adphi;
    fold  = (wrap1 > PI_Q12) ? 15'(TWO_PI_Q12 - wrap1) : wrap1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= lep_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_deta_r <= adeta;
    s1_dphi_r <= fold;
    s2_esq_r  <= 32'(s1_deta_r) * 32'(s1_deta_r);
    s2_psq_r  <= 30'(s1_dphi_r) * 30'(s1_dphi_r);
    s3_hit_r  <= (33'(s2_esq_r) + 33'(s2_psq_r)) < 33'(radius_sq);
  end

  assign stat.busy    = s1_vld_r | s2_vld_r | s3_vld_r;
  assign stat.hit_vld = s3_vld_r;
  assign stat.hit     = s3_hit_r;

endmodule

[rtl/jet_lepton_overlap_cleaning.sv]
// Top level of the jet/lepton overlap cleaning block: register file, lepton store,
// control sequencer and result register. Depends on jloc_pkg and jloc_cone_unit.
//
// Usage. Items arrive on the in_ channel under valid/ready. A clear item empties
// the lepton store and the sticky overflow flag of the event. A lepton item whose
// pt reaches lepton_min_pt has its eta and phi written into the store; a qualifying
// lepton beyond MAX_LEPTONS entries is dropped and sets the overflow flag. A jet
// item is run through the pt, b-tag, pileup and |eta| cuts (first failure wins),
// and a jet that passes them is compared against every stored lepton with
// deta^2 + dphi^2 < cone_radius^2. Each jet item yields exactly one result item on
// the out_ channel; clear, lepton and unused items yield none.
//
// Timing. Clear and lepton items are handled in the idle state. A jet rejected by a cut,
// or seen with an empty store, goes from acceptance straight to the result state.
// A jet that is scanned stays in the scan state while the store memory delivers one
// lepton per cycle and the three-stage distance pipeline drains.
// The block holds one item at a time; in_ready is high only while it is idle.
//
// Reset and stall. Reset loads the register defaults and empties the store; no
// clearing pass is needed. When the receiver stalls, the result waits in the output
// register and the block keeps taking clear and lepton items; a following jet
// waits in the result state until the output register is free.
module jet_lepton_overlap_cleaning #(
  parameter int MAX_LEPTONS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // input item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [15:0]        in_momentum_pt,
  input  logic signed [15:0] in_pseudorapidity,
  input  logic signed [14:0] in_azimuth,
  input  logic signed [15:0] in_btag_score,
  input  logic [7:0]         in_pileup_flag,
  // result item channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_keep,
  output logic [2:0]         out_reject_reason,
  output logic               out_store_overflowed,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import jloc_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEPTONS + 1);
  localparam int AW    = (MAX_LEPTONS > 1) ? $clog2(MAX_LEPTONS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEPTONS);

  // Configuration registers.
  logic [15:0]        jet_min_pt_r;
  logic signed [15:0] btag_max_r;
  logic [7:0]         pileup_min_r;
  logic [14:0]        abs_eta_max_r;
  logic [15:0]        lepton_min_pt_r;
  logic [14:0]        cone_radius_r;
  logic [29:0]        radius_sq_r;

  // Lepton store: phi in the low 15 bits, eta above.
  logic [30:0]        lep_mem [MAX_LEPTONS];
  logic [30:0]        rd_data_r;
  logic               rd_vld_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic [CNT_W-1:0]   lep_cnt_r;
  logic               ovf_r;

  // Jet under test.
  logic signed [15:0] jet_eta_r;
  logic signed [14:0] jet_phi_r;
  reason_t            reason_r;
  logic               hit_r;

  logic               out_valid_r;
  logic               out_keep_r;
  reason_t            out_reason_r;

  state_t             state_r, state_nxt;
  cone_stat_t         cone_stat;

  logic               in_acc;
  func_t              func;
  logic [15:0]        abs_eta;
  reason_t            cut_reason;
  reason_t            final_reason;
  logic               issue;
  logic               scan_done;
  logic               out_load;
  logic               lep_qual;

  assign cfg_ready = 1'b1;
  assign func      = func_t'(in_func);
  assign in_acc    = in_valid && in_ready;
  assign lep_qual  = in_momentum_pt >= lepton_min_pt_r;

  // Cut chain on the incoming jet; the most negative eta maps to 32768.
  always_comb begin
    abs_eta = in_pseudorapidity[15] ? 16'(-in_pseudorapidity) : in_pseudorapidity;
    priority if (in_momentum_pt < jet_min_pt_r) begin
      cut_reason = RSN_LOW_PT;
    end else if (in_btag_score > btag_max_r) begin
      cut_reason = RSN_BTAG;
    end else if (in_pileup_flag < pileup_min_r) begin
      cut_reason = RSN_PILEUP;
    end else if (abs_eta > 16'(abs_eta_max_r)) begin
      cut_reason = RSN_ETA;
    end else begin
      cut_reason = RSN_KEPT;
    end
  end

  assign final_reason = (reason_r == RSN_KEPT && hit_r) ? RSN_NEAR : reason_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && func == FUNC_JET) begin
          state_nxt = (cut_reason != RSN_KEPT || lep_cnt_r == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    scan_done = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN: begin
        issue     = rd_idx_r < lep_cnt_r;
        scan_done = !issue && !rd_vld_r && !cone_stat.busy;
      end
      ST_RESULT: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers; the squared radius is kept ready for the compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jet_min_pt_r    <= 16'd480;
      btag_max_r      <= 16'sd32767;
      pileup_min_r    <= 8'd0;
      abs_eta_max_r   <= 15'd19456;
      lepton_min_pt_r <= 16'd160;
      cone_radius_r   <= 15'd1228;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_JET_MIN_PT:    jet_min_pt_r    <= cfg_data;
        REG_BTAG_MAX:      btag_max_r      <= cfg_data;
        REG_PILEUP_MIN:    pileup_min_r    <= cfg_data[7:0];
        REG_ABS_ETA_MAX:   abs_eta_max_r   <= cfg_data[14:0];
        REG_LEPTON_MIN_PT: lepton_min_pt_r <= cfg_data;
        REG_CONE_RADIUS:   cone_radius_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    radius_sq_r <= 30'(cone_radius_r) * 30'(cone_radius_r);
  end

  // Store fill count and sticky overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lep_cnt_r <= '0;
      ovf_r     <= 1'b0;
    end else if (in_acc) begin
      if (func == FUNC_CLEAR) begin
        lep_cnt_r <= '0;
        ovf_r     <= 1'b0;
      end else if (func == FUNC_LEPTON && lep_qual) begin
        if (lep_cnt_r < CNT_MAX) begin
          lep_cnt_r <= lep_cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // Store writes happen only in the idle state and reads only during a scan,
  // so a read never meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (in_acc && func == FUNC_LEPTON && lep_qual && lep_cnt_r < CNT_MAX) begin
      lep_mem[lep_cnt_r[AW-1:0]] <= {in_pseudorapidity, in_azimuth};
    end
    if (issue) begin
      rd_data_r <= lep_mem[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_idx_r <= '0;
      hit_r    <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (in_acc && func == FUNC_JET) begin
        rd_idx_r <= '0;
        hit_r    <= 1'b0;
      end else begin
        if (issue) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
        if (cone_stat.hit_vld && cone_stat.hit) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && func == FUNC_JET) begin
      jet_eta_r <= in_pseudorapidity;
      jet_phi_r <= in_azimuth;
      reason_r  <= cut_reason;
    end
  end

  jloc_cone_unit u_cone (
    .clk       (clk),
    .rst_n     (rst_n),
    .lep_vld   (rd_vld_r),
    .jet_eta   (jet_eta_r),
    .jet_phi   (jet_phi_r),
    .lep_eta   (rd_data_r[30:15]),
    .lep_phi   (rd_data_r[14:0]),
    .radius_sq (radius_sq_r),
    .stat      (cone_stat)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_keep_r   <= (final_reason == RSN_KEPT);
      out_reason_r <= final_reason;
    end
  end

  // The overflow flag cannot change while a jet is in flight; it is sampled with the
  // result, so clear and lepton items taken while the result waits do not alter it.
  logic ovf_out_r;
  always_ff @(posedge clk) begin
    if (out_load) begin
      ovf_out_r <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_keep             = out_keep_r;
  assign out_reject_reason    = out_reason_r;
  assign out_store_overflowed = ovf_out_r;

endmodule

[rtl/jloc_checker.sv]
// Port-level checker for the jet/lepton overlap cleaning block, bound to its top level.
// Depends on jloc_pkg for the reason codes.
module jloc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_keep,
  input logic [2:0] out_reject_reason,
  input logic       out_store_overflowed
);
  import jloc_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_keep)
      && $stable(out_reject_reason) && $stable(out_store_overflowed))
    else $error("result changed while stalled");

  // Keep is set exactly when no reason was given.
  a_keep_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_keep == (out_reject_reason == RSN_KEPT))
    else $error("keep disagrees with reject reason");

  // Only defined reason codes appear.
  a_reason_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reject_reason == RSN_KEPT || out_reject_reason == RSN_LOW_PT
      || out_reject_reason == RSN_BTAG || out_reject_reason == RSN_PILEUP
      || out_reject_reason == RSN_ETA || out_reject_reason == RSN_NEAR)
    else $error("undefined reject reason");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind jet_lepton_overlap_cleaning jloc_checker u_jloc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_keep             (out_keep),
  .out_reject_reason    (out_reject_reason),
  .out_store_overflowed (out_store_overflowed)
);
